### rtl/fmeg_pkg.sv
// ----------------------------------------------------------------------------
// FM envelope generator package
// Shared types, codes, constants and table functions for the envelope block.
// ----------------------------------------------------------------------------
package fmeg_pkg;

  localparam int unsigned LEVEL_W    = 31;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned NOTE_W     = 7;
  localparam int unsigned KEY_W      = 4;
  localparam int unsigned RATE_W     = 5;
  localparam int unsigned ERATE_W    = 6;
  localparam int unsigned ERATE_MAX  = 63;
  localparam int unsigned INC_W      = 30;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [LEVEL_W-1:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [LEVEL_W-1:0] FLOOR_Q30 = 31'd1073742;
  localparam logic [63:0]        HALF_Q30  = 64'd536870912;
  localparam logic [63:0]        STEP_6DB  = 64'd538145694;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_KEY_ON  = 2'd1,
    ACT_KEY_OFF = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_RATE   = 3'd0,
    CFG_DECAY_RATE    = 3'd1,
    CFG_SUSTAIN_RATE  = 3'd2,
    CFG_RELEASE_RATE  = 3'd3,
    CFG_SUSTAIN_LEVEL = 3'd4,
    CFG_TOTAL_LEVEL   = 3'd5,
    CFG_KEY_SCALE     = 3'd6,
    CFG_MODE_FLAGS    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_ATTACK  = 2'd0,
    KIND_DECAY   = 2'd1,
    KIND_RELEASE = 2'd2
  } rate_kind_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [NOTE_W-1:0] note_number;
    logic [15:0]       velocity;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [GAIN_W-1:0]  note_gain;
    logic [2:0]         phase;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  typedef struct packed {
    logic [4:0] attack_rate;
    logic [4:0] decay_rate;
    logic [4:0] sustain_rate;
    logic [3:0] release_rate;
    logic [3:0] sustain_level;
    logic [6:0] total_level;
    logic [1:0] key_scale;
    logic [2:0] mode_flags;
  } cfg_regs_t;

  typedef struct packed {
    phase_e             phase;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] progress;
    logic [KEY_W-1:0]   key;
  } env_state_t;

  // Quarter-octave ladder of phase times in ns
  function automatic logic [63:0] base_ns(input rate_kind_e kind, input logic [1:0] sel);
    logic [63:0] b;
    if (kind == KIND_ATTACK) begin
      case (sel)
        2'd0:    b = 64'd148500;
        2'd1:    b = 64'd176597;
        2'd2:    b = 64'd210011;
        default: b = 64'd249746;
      endcase
    end else begin
      case (sel)
        2'd0:    b = 64'd450000;
        2'd1:    b = 64'd535143;
        2'd2:    b = 64'd636396;
        default: b = 64'd756807;
      endcase
    end
    return b;
  endfunction

  // Phase time for an effective rate, minimum-time clamps applied
  function automatic logic [63:0] time_ns(input rate_kind_e kind, input int unsigned erate);
    logic [63:0] t;
    logic [5:0]  d;
    d = 6'd0;
    if (erate >= 60) begin
      t = 64'd1000000;
    end else begin
      d = 6'(60 - erate);
      t = base_ns(kind, d[1:0]) << d[5:2];
    end
    if (kind == KIND_ATTACK && t < 64'd1000000) t = 64'd1000000;
    if (kind == KIND_DECAY && t < 64'd100000) t = 64'd100000;
    if (kind == KIND_RELEASE && t < 64'd5000000) t = 64'd5000000;
    return t;
  endfunction

  function automatic logic [LEVEL_W-1:0] sustain_gain(input logic [3:0] sl);
    logic [LEVEL_W-1:0] g;
    case (sl)
      4'd0:    g = 31'd1073741824;
      4'd1:    g = 31'd760150998;
      4'd2:    g = 31'd538145694;
      4'd3:    g = 31'd380977976;
      4'd4:    g = 31'd269711752;
      4'd5:    g = 31'd190941298;
      4'd6:    g = 31'd135176087;
      4'd7:    g = 31'd95697341;
      4'd8:    g = 31'd67748529;
      4'd9:    g = 31'd47962283;
      4'd10:   g = 31'd33954698;
      4'd11:   g = 31'd24038085;
      4'd12:   g = 31'd17017661;
      4'd13:   g = 31'd12047582;
      4'd14:   g = 31'd8529034;
      default: g = 31'd0;
    endcase
    return g;
  endfunction

  function automatic logic [63:0] tl_fine(input logic [2:0] f);
    logic [63:0] g;
    case (f)
      3'd0:    g = 64'd1073741824;
      3'd1:    g = 64'd984917536;
      3'd2:    g = 64'd903441154;
      3'd3:    g = 64'd828704874;
      3'd4:    g = 64'd760150998;
      3'd5:    g = 64'd697268217;
      3'd6:    g = 64'd639587358;
      default: g = 64'd586678122;
    endcase
    return g;
  endfunction

  // Total-level gain: fine step, then one rounded 6 dB step per coarse count.
  // Evaluated at elaboration only.
  function automatic logic [63:0] tl_gain(input logic [6:0] tl);
    logic [63:0] g;
    g = tl_fine(tl[2:0]);
    for (int q = 0; q < 16; q++) begin
      if (q < int'(tl[6:3])) g = (g * STEP_6DB + HALF_Q30) >> 30;
    end
    return g;
  endfunction

  // Key code 0..15 from a note: two per octave, semitones 8..11 of an octave add one.
  // Octave found by compares against the twelve-note boundaries.
  function automatic logic [KEY_W-1:0] key_code(input logic [NOTE_W-1:0] n);
    logic [3:0]        blk;
    logic [NOTE_W-1:0] base;
    logic [NOTE_W-1:0] semi;
    logic [2:0]        oct;
    blk  = 4'd0;
    base = '0;
    for (int k = 1; k <= 10; k++) begin
      if (n >= NOTE_W'(12 * k)) begin
        blk  = blk + 4'd1;
        base = NOTE_W'(12 * k);
      end
    end
    semi = n - base;
    oct  = (blk == 4'd0) ? 3'd0 : (blk > 4'd8) ? 3'd7 : 3'(blk - 4'd1);
    return KEY_W'({oct, (semi > NOTE_W'(7))});
  endfunction

endpackage

### rtl/fmeg_stream_if.sv
// ----------------------------------------------------------------------------
// FM envelope generator stream interface
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface fmeg_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/fm_adssr_envelope_generator_unit.sv
// ----------------------------------------------------------------------------
// FM attack/decay/sustain-rate/release envelope generator
// Single-voice register-mode envelope, one request per clock while out_o is not stalled.
// ----------------------------------------------------------------------------
// Each request on in_i (sample tick, key-on or key-off) yields exactly one
// result on out_o: level in Q1.30, key-on gain in Q1.15 and the phase. A new
// request is taken every clock unless out_o stalls; the request is held in an
// input register and the whole envelope update (increment table lookup, one
// add or subtract and the limit compares, plus the 16x31 key-on gain multiply)
// runs between that register and the result register, and the envelope state
// register loops back through that same logic. A stalled out_o holds the
// result register and backs up into the input register, after which in_i.ready
// drops. Per-sample increments are fixed tables built at elaboration from
// SAMPLE_RATE_HZ and the rate register maxima. Configuration writes on cfg_i
// are always accepted and must only be made while no request is in flight.
module fm_adssr_envelope_generator_unit import fmeg_pkg::*; #(
  parameter int unsigned RATE_REG_MAX    = 31,
  parameter int unsigned RELEASE_REG_MAX = 15,
  parameter int unsigned SAMPLE_RATE_HZ  = 48000
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fmeg_stream_if.sink   in_i,
  fmeg_stream_if.source out_o,
  fmeg_stream_if.sink   cfg_i
);

  cfg_regs_t  cfg_q;
  logic       in_valid_q;
  in_t        in_q;
  env_state_t state_q;
  env_state_t state_d;
  logic       out_valid_q;
  out_t       out_q;
  out_t       result_d;
  in_t        in_req;
  cfg_t       cfg_req;
  logic       advance;
  logic       step_en;

  assign in_req  = in_i.payload;
  assign cfg_req = cfg_i.payload;

  // result register free or being emptied this cycle
  assign advance     = !out_valid_q || out_o.ready;
  assign step_en     = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // --- configuration registers ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_rate   <= 5'd31;
      cfg_q.decay_rate    <= '0;
      cfg_q.sustain_rate  <= '0;
      cfg_q.release_rate  <= 4'd15;
      cfg_q.sustain_level <= '0;
      cfg_q.total_level   <= '0;
      cfg_q.key_scale     <= '0;
      cfg_q.mode_flags    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_req.index))
        CFG_ATTACK_RATE:   cfg_q.attack_rate   <= cfg_req.data[4:0];
        CFG_DECAY_RATE:    cfg_q.decay_rate    <= cfg_req.data[4:0];
        CFG_SUSTAIN_RATE:  cfg_q.sustain_rate  <= cfg_req.data[4:0];
        CFG_RELEASE_RATE:  cfg_q.release_rate  <= cfg_req.data[3:0];
        CFG_SUSTAIN_LEVEL: cfg_q.sustain_level <= cfg_req.data[3:0];
        CFG_TOTAL_LEVEL:   cfg_q.total_level   <= cfg_req.data[6:0];
        CFG_KEY_SCALE:     cfg_q.key_scale     <= cfg_req.data[1:0];
        CFG_MODE_FLAGS:    cfg_q.mode_flags    <= cfg_req.data[2:0];
      endcase
    end
  end

  // --- input register ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) in_q <= in_req;
  end

  // --- envelope update ---
  fmeg_env_step #(
    .RATE_REG_MAX    (RATE_REG_MAX),
    .RELEASE_REG_MAX (RELEASE_REG_MAX),
    .SAMPLE_RATE_HZ  (SAMPLE_RATE_HZ)
  ) u_step (
    .state_i  (state_q),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase    <= PH_IDLE;
      state_q.level    <= '0;
      state_q.progress <= '0;
      state_q.key      <= '0;
    end else if (step_en) begin
      state_q <= state_d;
    end
  end

  // --- result register ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) out_q <= result_d;
  end

  // --- assertions ---
  a_state_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en |=> $stable(state_q))
    else $error("envelope state changed without a request");

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.level <= ONE_Q30)
    else $error("envelope level above one");

  a_progress_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.progress < ONE_Q30)
    else $error("release progress not below one");

  a_result_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared without a request in the input register");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("input register lost a request under stall");

endmodule

### rtl/fmeg_inc_rom.sv
// ----------------------------------------------------------------------------
// FM envelope generator increment table
// Rate register plus key offset to per-sample level increment, one kind.
// ----------------------------------------------------------------------------
module fmeg_inc_rom import fmeg_pkg::*; #(
  parameter rate_kind_e  KIND           = KIND_DECAY,
  parameter int unsigned REG_MAX        = 31,
  parameter int unsigned SAMPLE_RATE_HZ = 48000
) (
  input  logic [RATE_W-1:0] rate_i,
  input  logic [KEY_W-1:0]  ksr_i,
  output logic [INC_W-1:0]  inc_o
);

  localparam logic [63:0] NUM      = 64'd1073741824000000000;
  localparam logic [63:0] FS       = 64'(SAMPLE_RATE_HZ);
  localparam logic [63:0] FADE_DEN = 64'd5000000000 * FS;
  localparam logic [63:0] FADE_INC = (NUM + FADE_DEN / 2) / FADE_DEN;

  logic [ERATE_W-1:0] scale_tbl [2**RATE_W];
  logic [INC_W-1:0]   inc_tbl   [2**ERATE_W];
  logic [ERATE_W:0]   erate_sum;
  logic [ERATE_W-1:0] erate;

  // register scaled to 0..63, saturating past the maximum
  for (genvar r = 0; r < 2**RATE_W; r++) begin : g_scale
    localparam logic [31:0] SC = 32'((r * ERATE_MAX) / REG_MAX);
    assign scale_tbl[r] = (SC > 32'(ERATE_MAX)) ? ERATE_W'(ERATE_MAX) : SC[ERATE_W-1:0];
  end

  for (genvar e = 0; e < 2**ERATE_W; e++) begin : g_inc
    localparam logic [63:0] DEN = time_ns(KIND, e) * FS;
    localparam logic [63:0] INC = (NUM + DEN / 2) / DEN;
    assign inc_tbl[e] = INC[INC_W-1:0];
  end

  assign erate_sum = {1'b0, scale_tbl[rate_i]} + (ERATE_W + 1)'(ksr_i);
  assign erate     = (erate_sum > (ERATE_W + 1)'(ERATE_MAX)) ? ERATE_W'(ERATE_MAX)
                                                             : erate_sum[ERATE_W-1:0];

  always_comb begin
    if (KIND == KIND_RELEASE && rate_i <= RATE_W'(1)) begin
      inc_o = FADE_INC[INC_W-1:0];      // fixed slow fade
    end else if (rate_i == '0) begin
      inc_o = '0;
    end else begin
      inc_o = inc_tbl[erate];
    end
  end

endmodule

### rtl/fmeg_gain.sv
// ----------------------------------------------------------------------------
// FM envelope generator key-on gain
// Velocity times total-level gain, rounded back to Q1.15.
// ----------------------------------------------------------------------------
module fmeg_gain import fmeg_pkg::*; (
  input  logic [6:0]        total_level_i,
  input  logic [15:0]       velocity_i,
  output logic [GAIN_W-1:0] gain_o
);

  localparam int unsigned PROD_W = 16 + LEVEL_W;

  logic [LEVEL_W-1:0] tl_tbl [128];
  logic [PROD_W-1:0]  prod;

  for (genvar g = 0; g < 128; g++) begin : g_tl
    localparam logic [63:0] TLG = tl_gain(7'(g));
    assign tl_tbl[g] = TLG[LEVEL_W-1:0];
  end

  assign prod   = PROD_W'(velocity_i) * PROD_W'(tl_tbl[total_level_i])
                + PROD_W'(HALF_Q30);
  assign gain_o = prod[30 +: GAIN_W];

endmodule

### rtl/fmeg_env_step.sv
// ----------------------------------------------------------------------------
// FM envelope generator step logic
// Next envelope state and result for one request against the current state.
// ----------------------------------------------------------------------------
module fmeg_env_step import fmeg_pkg::*; #(
  parameter int unsigned RATE_REG_MAX    = 31,
  parameter int unsigned RELEASE_REG_MAX = 15,
  parameter int unsigned SAMPLE_RATE_HZ  = 48000
) (
  input  env_state_t state_i,
  input  in_t        item_i,
  input  cfg_regs_t  cfg_i,
  output env_state_t state_o,
  output out_t       result_o
);

  logic               bypass;
  logic               ignore_off;
  logic               hold;
  logic [KEY_W-1:0]   ksr;
  logic [RATE_W-1:0]  dec_rate;
  logic [INC_W-1:0]   att_inc;
  logic [INC_W-1:0]   dec_inc;
  logic [INC_W-1:0]   rel_inc;
  logic [INC_W-1:0]   rel_dec;
  logic [LEVEL_W-1:0] sus;
  logic [GAIN_W-1:0]  key_gain;
  logic [LEVEL_W:0]   att_sum;
  logic [LEVEL_W:0]   prog_sum;
  logic [LEVEL_W-1:0] dec_gap;
  env_state_t         tick_state;
  env_state_t         next_state;
  logic [GAIN_W-1:0]  gain;

  assign bypass     = cfg_i.mode_flags[0];
  assign ignore_off = cfg_i.mode_flags[1];
  assign hold       = cfg_i.mode_flags[2];
  assign ksr        = state_i.key >> (~cfg_i.key_scale);
  assign dec_rate   = (state_i.phase == PH_SUSTAIN) ? cfg_i.sustain_rate : cfg_i.decay_rate;
  assign sus        = sustain_gain(cfg_i.sustain_level);

  fmeg_inc_rom #(
    .KIND           (KIND_ATTACK),
    .REG_MAX        (RATE_REG_MAX),
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
  ) u_att_rom (
    .rate_i (cfg_i.attack_rate),
    .ksr_i  (ksr),
    .inc_o  (att_inc)
  );

  fmeg_inc_rom #(
    .KIND           (KIND_DECAY),
    .REG_MAX        (RATE_REG_MAX),
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
  ) u_dec_rom (
    .rate_i (dec_rate),
    .ksr_i  (ksr),
    .inc_o  (dec_inc)
  );

  fmeg_inc_rom #(
    .KIND           (KIND_RELEASE),
    .REG_MAX        (RELEASE_REG_MAX),
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
  ) u_rel_rom (
    .rate_i (RATE_W'(cfg_i.release_rate)),
    .ksr_i  (ksr),
    .inc_o  (rel_inc)
  );

  fmeg_gain u_gain (
    .total_level_i (cfg_i.total_level),
    .velocity_i    (item_i.velocity),
    .gain_o        (key_gain)
  );

  assign att_sum  = (LEVEL_W + 1)'(state_i.level) + (LEVEL_W + 1)'(att_inc);
  assign prog_sum = (LEVEL_W + 1)'(state_i.progress) + (LEVEL_W + 1)'(rel_inc);
  assign dec_gap  = state_i.level - sus;
  assign rel_dec  = hold ? '0 : rel_inc;

  // one sample of envelope advance
  always_comb begin
    tick_state = state_i;
    unique case (state_i.phase)
      PH_ATTACK: begin
        if (att_sum >= (LEVEL_W + 1)'(ONE_Q30)) begin
          tick_state.level = ONE_Q30;
          tick_state.phase = PH_DECAY;
        end else begin
          tick_state.level = att_sum[LEVEL_W-1:0];
        end
      end
      PH_DECAY: begin
        if (cfg_i.decay_rate == '0) begin
          tick_state.level = ONE_Q30;
          tick_state.phase = PH_SUSTAIN;
        end else if (state_i.level > sus) begin
          if (dec_inc != '0) begin
            if (dec_gap <= LEVEL_W'(dec_inc)) begin
              tick_state.level = sus;
              tick_state.phase = PH_SUSTAIN;
            end else begin
              tick_state.level = state_i.level - LEVEL_W'(dec_inc);
            end
          end
        end else begin
          tick_state.level = sus;
          tick_state.phase = PH_SUSTAIN;
        end
      end
      PH_SUSTAIN: begin
        if (dec_inc != '0) begin
          if ((LEVEL_W + 1)'(state_i.level)
              <= (LEVEL_W + 1)'(dec_inc) + (LEVEL_W + 1)'(FLOOR_Q30)) begin
            tick_state.level = '0;
            tick_state.phase = PH_IDLE;
          end else begin
            tick_state.level = state_i.level - LEVEL_W'(dec_inc);
          end
        end
      end
      PH_RELEASE: begin
        if (prog_sum >= (LEVEL_W + 1)'(ONE_Q30)) begin
          tick_state.progress = '0;
          tick_state.level    = '0;
          tick_state.phase    = PH_IDLE;
        end else begin
          tick_state.progress = prog_sum[LEVEL_W-1:0];
          if ((LEVEL_W + 1)'(state_i.level)
              <= (LEVEL_W + 1)'(rel_dec) + (LEVEL_W + 1)'(FLOOR_Q30)) begin
            tick_state.level = '0;
            tick_state.phase = PH_IDLE;
          end else begin
            tick_state.level = state_i.level - LEVEL_W'(rel_dec);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // next state by request kind
  always_comb begin
    next_state = state_i;
    case (item_i.action)
      ACT_TICK: begin
        if (bypass) next_state.level = ONE_Q30;
        else        next_state = tick_state;
      end
      ACT_KEY_ON: begin
        next_state.key      = key_code(item_i.note_number);
        next_state.progress = '0;
        if (!bypass) next_state.phase = PH_ATTACK;
      end
      ACT_KEY_OFF: begin
        if (!ignore_off && !bypass) begin
          next_state.phase    = PH_RELEASE;
          next_state.progress = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // result fields
  always_comb begin
    gain = '0;
    if (item_i.action == ACT_KEY_ON) gain = bypass ? item_i.velocity : key_gain;
    result_o.level     = bypass ? ONE_Q30 : next_state.level;
    result_o.note_gain = gain;
    result_o.phase     = next_state.phase;
  end

  assign state_o = next_state;

endmodule
